@@ src/hrlp_pkg.sv @@
// Shared types and constants for the HTTP request-line parser.
// Used by hrlp_step and http_request_line_parser_core; depends on nothing.
package hrlp_pkg;

   // Parser phases
   typedef enum logic [2:0] {
      PH_SKIP_LEAD  = 3'd0,
      PH_METHOD     = 3'd1,
      PH_SKIP_URL   = 3'd2,
      PH_URL        = 3'd3,
      PH_SKIP_VER   = 3'd4,
      PH_VERSION    = 3'd5,
      PH_LATER      = 3'd6,
      PH_FAULT      = 3'd7
   } phase_type;

   // Parser state carried from byte to byte (offset counter kept apart)
   typedef struct packed {
      phase_type   phase;
      logic [3:0]  progress;
      logic [1:0]  kind;
      logic        cr_seen;
      logic [11:0] url_begin;
      logic [11:0] url_count;
      logic        fault;
      logic        nonempty;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:     PH_SKIP_LEAD,
      progress:  4'd0,
      kind:      2'd0,
      cr_seen:   1'b0,
      url_begin: 12'd0,
      url_count: 12'd0,
      fault:     1'b0,
      nonempty:  1'b0
   };

   // Per-byte result
   typedef struct packed {
      logic [11:0] url_length;
      logic [11:0] url_start;
      logic [1:0]  method_code;
      logic [1:0]  status;
      logic [1:0]  line_event;
      logic [2:0]  byte_class;
      logic [11:0] byte_offset;
   } result_type;

   // Byte classes
   localparam logic [2:0] CLS_BLANK   = 3'd0;
   localparam logic [2:0] CLS_METHOD  = 3'd1;
   localparam logic [2:0] CLS_URL     = 3'd2;
   localparam logic [2:0] CLS_VERSION = 3'd3;
   localparam logic [2:0] CLS_CRLF    = 3'd4;
   localparam logic [2:0] CLS_LATER   = 3'd5;
   localparam logic [2:0] CLS_FAULT   = 3'd6;

   // Line events
   localparam logic [1:0] EV_NONE       = 2'd0;
   localparam logic [1:0] EV_COMPLETE   = 2'd1;
   localparam logic [1:0] EV_FAULT      = 2'd2;
   localparam logic [1:0] EV_INCOMPLETE = 2'd3;

   // Request-line status
   localparam logic [1:0] ST_PROGRESS = 2'd0;
   localparam logic [1:0] ST_COMPLETE = 2'd1;
   localparam logic [1:0] ST_FAULT    = 2'd2;

   // Method codes / match mask bits
   localparam logic [1:0] METH_NONE = 2'd0;
   localparam logic [1:0] METH_GET  = 2'd1;
   localparam logic [1:0] METH_POST = 2'd2;
   localparam logic [1:0] METH_ALL  = 2'd3;

   // Characters
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LO_A = 8'h61;
   localparam logic [7:0] CH_LO_Z = 8'h7A;
   localparam logic [7:0] CASE_DELTA = 8'h20;

   localparam logic [3:0] GET_LEN  = 4'd3;
   localparam logic [3:0] POST_LEN = 4'd4;
   localparam logic [3:0] PROGRESS_MAX = 4'd15;
   localparam logic [11:0] URL_COUNT_MAX = 12'd4095;

   // Method words; GET padded to four entries, pad never matches (guarded by length)
   localparam logic [7:0] GET_WORD  [4] = '{8'h47, 8'h45, 8'h54, 8'h00};
   localparam logic [7:0] POST_WORD [4] = '{8'h50, 8'h4F, 8'h53, 8'h54};

endpackage

@@ src/http_request_line_parser_core.sv @@
// A byte accepted into the input register is parsed by hrlp_step, and its result is
// registered in the result register, which drives rsp_*.
// Throughput: one byte per cycle unless stalled; input register, one pass of parse
// logic (hrlp_step), result register. A stalled result holds the result register;
// the input register then fills and req_tready drops until the result transfers.
// Reset: synchronous, active high; clears the pipeline valids and parser state.
module http_request_line_parser_core #(
   parameter int MAX_REQUEST_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] start_of_request
   input  logic        req_tlast,   // end_of_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [11:0] byte_offset, [14:12] byte_class,
                                    // [16:15] line_event, [18:17] request_line_status,
                                    // [20:19] method_code, [32:21] url_start,
                                    // [44:33] url_length, [47:45] zero
);

   // Top level of the HTTP request-line parser; depends on hrlp_pkg and hrlp_step.
   // req_tuser (start of request) restarts the parser and the offset counter.
   localparam int OFFSET_LIMIT = (MAX_REQUEST_BYTES - 1 > 4095) ? 4095 : MAX_REQUEST_BYTES - 1;
   localparam logic [11:0] OFFSET_TOP = 12'(OFFSET_LIMIT);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_sor_ff;
   logic                 in_eod_ff;
   logic                 out_valid_ff;
   hrlp_pkg::result_type out_data_ff;
   hrlp_pkg::state_type  state_ff;
   hrlp_pkg::state_type  state_in;
   hrlp_pkg::state_type  cur_state;
   logic [11:0]          offset_ff;
   logic [11:0]          offset_in;
   logic [11:0]          cur_offset;
   hrlp_pkg::result_type step_result;
   logic                 advance;
   logic                 fire;

   // Handshake: the result stage moves when empty or drained
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign fire       = in_valid_ff && advance;

   // Start of request restarts the parser before this byte
   assign cur_state  = in_sor_ff ? hrlp_pkg::STATE_RESET : state_ff;
   assign cur_offset = in_sor_ff ? 12'd0 : offset_ff;
   assign offset_in  = (cur_offset < OFFSET_TOP) ? cur_offset + 12'd1 : cur_offset;

   hrlp_step u_step (
      .cur         (cur_state),
      .data_byte   (in_byte_ff),
      .end_of_data (in_eod_ff),
      .offset      (cur_offset),
      .nxt         (state_in),
      .result      (step_result)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= hrlp_pkg::STATE_RESET;
         offset_ff    <= 12'd0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            state_ff  <= state_in;
            offset_ff <= offset_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_sor_ff  <= req_tuser;
         in_eod_ff  <= req_tlast;
      end
      if (fire) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_data_ff};

endmodule

@@ src/hrlp_step.sv @@
// Per-byte next-state and result logic of the request-line parser.
// Purely combinational; depends on hrlp_pkg.
module hrlp_step (
   input  hrlp_pkg::state_type  cur,
   input  logic [7:0]           data_byte,
   input  logic                 end_of_data,
   input  logic [11:0]          offset,
   output hrlp_pkg::state_type  nxt,
   output hrlp_pkg::result_type result
);

   // Request-line failure; faults on later lines leave the status alone
   function automatic hrlp_pkg::state_type enter_fault(input hrlp_pkg::state_type s);
      hrlp_pkg::state_type r;
      r = s;
      if (s.phase != hrlp_pkg::PH_LATER && s.phase != hrlp_pkg::PH_FAULT) begin
         r.fault = 1'b1;
         if (s.phase == hrlp_pkg::PH_SKIP_LEAD || s.phase == hrlp_pkg::PH_METHOD) begin
            r.kind = hrlp_pkg::METH_NONE;
         end
      end
      r.phase = hrlp_pkg::PH_FAULT;
      return r;
   endfunction

   // Narrow the still-matching method mask by one token character
   function automatic hrlp_pkg::state_type method_char(input hrlp_pkg::state_type s,
                                                       input logic [7:0] b);
      hrlp_pkg::state_type r;
      logic [7:0]          up;
      r  = s;
      up = (b >= hrlp_pkg::CH_LO_A && b <= hrlp_pkg::CH_LO_Z) ?
           b - hrlp_pkg::CASE_DELTA : b;
      if (s.progress >= hrlp_pkg::GET_LEN ||
          up != hrlp_pkg::GET_WORD[s.progress[1:0]]) begin
         r.kind[0] = 1'b0;
      end
      if (s.progress >= hrlp_pkg::POST_LEN ||
          up != hrlp_pkg::POST_WORD[s.progress[1:0]]) begin
         r.kind[1] = 1'b0;
      end
      if (s.progress < hrlp_pkg::PROGRESS_MAX) begin
         r.progress = s.progress + 4'd1;
      end
      return r;
   endfunction

   logic       is_blank;
   logic [2:0] cls;
   logic [1:0] ev;

   assign is_blank = data_byte inside {hrlp_pkg::CH_SP, hrlp_pkg::CH_TAB};

   // Line framing and request-line parsing
   always_comb begin
      nxt = cur;
      cls = hrlp_pkg::CLS_BLANK;
      ev  = hrlp_pkg::EV_NONE;
      if (cur.phase == hrlp_pkg::PH_FAULT) begin
         cls = hrlp_pkg::CLS_FAULT;
      end else if (cur.cr_seen) begin
         nxt.cr_seen = 1'b0;
         if (data_byte == hrlp_pkg::CH_LF) begin
            cls = hrlp_pkg::CLS_CRLF;
            ev  = hrlp_pkg::EV_COMPLETE;
            if (cur.phase != hrlp_pkg::PH_LATER) begin
               if (cur.phase == hrlp_pkg::PH_VERSION && cur.nonempty) begin
                  nxt.phase = hrlp_pkg::PH_LATER;
               end else begin
                  nxt = enter_fault(nxt);
               end
            end
         end else begin
            cls = hrlp_pkg::CLS_FAULT;
            ev  = hrlp_pkg::EV_FAULT;
            nxt = enter_fault(nxt);
         end
      end else if (data_byte == hrlp_pkg::CH_CR) begin
         cls = hrlp_pkg::CLS_CRLF;
         nxt.cr_seen = 1'b1;
      end else if (data_byte == hrlp_pkg::CH_LF) begin
         // bare LF
         cls = hrlp_pkg::CLS_CRLF;
         ev  = hrlp_pkg::EV_FAULT;
         nxt = enter_fault(nxt);
      end else begin
         case (cur.phase)
            hrlp_pkg::PH_SKIP_LEAD: begin
               if (!is_blank) begin
                  nxt.phase    = hrlp_pkg::PH_METHOD;
                  nxt.kind     = hrlp_pkg::METH_ALL;
                  nxt.progress = 4'd0;
                  nxt          = method_char(nxt, data_byte);
                  cls          = hrlp_pkg::CLS_METHOD;
               end
            end
            hrlp_pkg::PH_METHOD: begin
               if (data_byte == hrlp_pkg::CH_SP) begin
                  if (cur.kind[0] && cur.progress == hrlp_pkg::GET_LEN) begin
                     nxt.kind  = hrlp_pkg::METH_GET;
                     nxt.phase = hrlp_pkg::PH_SKIP_URL;
                  end else if (cur.kind[1] && cur.progress == hrlp_pkg::POST_LEN) begin
                     nxt.kind  = hrlp_pkg::METH_POST;
                     nxt.phase = hrlp_pkg::PH_SKIP_URL;
                  end else begin
                     cls = hrlp_pkg::CLS_FAULT;
                     nxt = enter_fault(nxt);
                  end
               end else begin
                  nxt = method_char(nxt, data_byte);
                  cls = hrlp_pkg::CLS_METHOD;
               end
            end
            hrlp_pkg::PH_SKIP_URL: begin
               if (!is_blank) begin
                  nxt.phase     = hrlp_pkg::PH_URL;
                  nxt.url_begin = offset;
                  nxt.url_count = 12'd1;
                  cls           = hrlp_pkg::CLS_URL;
               end
            end
            hrlp_pkg::PH_URL: begin
               if (data_byte == hrlp_pkg::CH_SP) begin
                  nxt.phase = hrlp_pkg::PH_SKIP_VER;
               end else begin
                  if (cur.url_count < hrlp_pkg::URL_COUNT_MAX) begin
                     nxt.url_count = cur.url_count + 12'd1;
                  end
                  cls = hrlp_pkg::CLS_URL;
               end
            end
            hrlp_pkg::PH_SKIP_VER: begin
               if (!is_blank) begin
                  nxt.phase    = hrlp_pkg::PH_VERSION;
                  nxt.nonempty = 1'b1;
                  cls          = hrlp_pkg::CLS_VERSION;
               end
            end
            hrlp_pkg::PH_VERSION: cls = hrlp_pkg::CLS_VERSION;
            default:              cls = hrlp_pkg::CLS_LATER;
         endcase
      end

      // Open line at end of data
      if (end_of_data && ev == hrlp_pkg::EV_NONE && nxt.phase != hrlp_pkg::PH_FAULT) begin
         ev = hrlp_pkg::EV_INCOMPLETE;
      end
   end

   // Result fields, taken from the updated state
   always_comb begin
      result.byte_offset = offset;
      result.byte_class  = cls;
      result.line_event  = ev;
      if (nxt.fault) begin
         result.status = hrlp_pkg::ST_FAULT;
      end else if (nxt.phase == hrlp_pkg::PH_LATER || nxt.phase == hrlp_pkg::PH_FAULT) begin
         result.status = hrlp_pkg::ST_COMPLETE;
      end else begin
         result.status = hrlp_pkg::ST_PROGRESS;
      end
      result.method_code = (nxt.phase == hrlp_pkg::PH_METHOD) ? hrlp_pkg::METH_NONE : nxt.kind;
      result.url_start   = nxt.url_begin;
      result.url_length  = nxt.url_count;
   end

endmodule

@@ src/hrlp_checker.sv @@
// Port-level checks for http_request_line_parser_core, with its bind.
// Depends on the top level's ports only.
module hrlp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Nothing comes out the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Class code seven is never produced
   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[14:12] != 3'd7)
      else $error("byte class out of range");

   // A complete request line has a known method and a URL
   a_complete_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[18:17] == 2'd1 |->
         rsp_tdata[20:19] != 2'd0 && rsp_tdata[44:33] != 12'd0)
      else $error("complete status without method or URL");

   // A byte seen after a fault never reports an open line
   a_fault_no_open: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[14:12] == 3'd6 |-> rsp_tdata[16:15] != 2'd3)
      else $error("open-line event on a faulted byte");

endmodule

bind http_request_line_parser_core hrlp_checker u_hrlp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
